[hw/rtl/status_led_pattern_generator_macros.svh]
// Assertion macros shared by the status LED pattern generator RTL.
`ifndef STATUS_LED_PATTERN_GENERATOR_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SLPG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define SLPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/slpg_pkg.sv]
// Shared types and constants of the status LED pattern generator.
package slpg_pkg;

    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam logic [7:0]  PEAK_DUTY = 8'd150;

    // Register reset values
    localparam logic [1:0]  RST_LED_MODE       = 2'd0;
    localparam logic [7:0]  RST_BLINK_COUNT    = 8'd0;
    localparam logic [7:0]  RST_LED_LEVEL      = 8'd20;
    localparam logic [15:0] RST_BLINK_INTERVAL = 16'd100;
    localparam logic [15:0] RST_PULSE_INTERVAL = 16'd5;
    localparam logic [15:0] RST_PAUSE_TICKS    = 16'd1000;
    localparam logic [15:0] RST_LOOP_TICKS     = 16'd10;

    // Register word indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_LED_MODE       = 3'd0,
        REG_BLINK_COUNT    = 3'd1,
        REG_LED_LEVEL      = 3'd2,
        REG_BLINK_INTERVAL = 3'd3,
        REG_PULSE_INTERVAL = 3'd4,
        REG_PAUSE_TICKS    = 3'd5,
        REG_LOOP_TICKS     = 3'd6
    } reg_idx_t;

    // Mode codes
    localparam logic [1:0] MODE_STEADY = 2'd0;
    localparam logic [1:0] MODE_BLINK  = 2'd1;
    localparam logic [1:0] MODE_INVERT = 2'd2;
    localparam logic [1:0] MODE_PULSE  = 2'd3;

    typedef struct packed {
        logic [1:0]  led_mode;
        logic [7:0]  blink_count;
        logic [7:0]  led_level;
        logic [15:0] blink_interval;
        logic [15:0] pulse_interval;
        logic [15:0] pause_ticks;
        logic [15:0] loop_ticks;
    } cfg_t;

    // Treat a zero interval as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

[hw/rtl/slpg_regs.sv]
// APB-style configuration register file of the status LED pattern generator.
module slpg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpg_pkg::ADDR_W-1:0] paddr,
    input  logic [slpg_pkg::DATA_W-1:0] pwdata,
    output logic [slpg_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output slpg_pkg::cfg_t              cfg,
    output logic                        mode_wr
);
    import slpg_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready  = 1'b1;
    assign idx     = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign mode_wr = wr_en && (idx == REG_LED_MODE);
    assign cfg     = cfg_reg;

    // Hold register contents, update on a write transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.led_mode       <= RST_LED_MODE;
            cfg_reg.blink_count    <= RST_BLINK_COUNT;
            cfg_reg.led_level      <= RST_LED_LEVEL;
            cfg_reg.blink_interval <= RST_BLINK_INTERVAL;
            cfg_reg.pulse_interval <= RST_PULSE_INTERVAL;
            cfg_reg.pause_ticks    <= RST_PAUSE_TICKS;
            cfg_reg.loop_ticks     <= RST_LOOP_TICKS;
        end else if (wr_en) begin
            unique case (idx)
                REG_LED_MODE:       cfg_reg.led_mode       <= pwdata[1:0];
                REG_BLINK_COUNT:    cfg_reg.blink_count    <= pwdata[7:0];
                REG_LED_LEVEL:      cfg_reg.led_level      <= pwdata[7:0];
                REG_BLINK_INTERVAL: cfg_reg.blink_interval <= pwdata[15:0];
                REG_PULSE_INTERVAL: cfg_reg.pulse_interval <= pwdata[15:0];
                REG_PAUSE_TICKS:    cfg_reg.pause_ticks    <= pwdata[15:0];
                REG_LOOP_TICKS:     cfg_reg.loop_ticks     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register on reads
    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_LED_MODE:       prdata = {30'd0, cfg_reg.led_mode};
            REG_BLINK_COUNT:    prdata = {24'd0, cfg_reg.blink_count};
            REG_LED_LEVEL:      prdata = {24'd0, cfg_reg.led_level};
            REG_BLINK_INTERVAL: prdata = {16'd0, cfg_reg.blink_interval};
            REG_PULSE_INTERVAL: prdata = {16'd0, cfg_reg.pulse_interval};
            REG_PAUSE_TICKS:    prdata = {16'd0, cfg_reg.pause_ticks};
            REG_LOOP_TICKS:     prdata = {16'd0, cfg_reg.loop_ticks};
            default:            prdata = '0;
        endcase
    end

endmodule

[hw/rtl/slpg_core.sv]
// Pattern state machine: phase, hold timer, repeat count and ramp of the LED duty.
module slpg_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  slpg_pkg::cfg_t cfg,
    input  logic           mode_wr,
    input  logic           step,
    input  logic           tick,
    output logic [7:0]     duty,
    output logic           pass_start
);
    import slpg_pkg::*;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_UP     = 3'd3,
        PH_DOWN   = 3'd4,
        PH_PAUSE  = 3'd5,
        PH_LOOP   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next, ph1;
    logic [7:0]  repeat_reg, repeat_next, rep1;
    logic [15:0] hold_reg, hold_next, hold1;
    logic [7:0]  ramp_reg, ramp_next, ramp1;
    logic [7:0]  duty_reg, duty_next, duty1;
    logic        start1;
    logic [15:0] len;
    logic        phase_done;
    logic        inverted;
    logic [7:0]  ramp_inc;

    assign inverted = (cfg.led_mode == MODE_INVERT);
    assign ramp_inc = ramp1 + 8'd1;

    // Begin a pass when the phase is start or an unused code
    always_comb begin
        ph1    = phase_reg;
        rep1   = repeat_reg;
        hold1  = hold_reg;
        ramp1  = ramp_reg;
        duty1  = duty_reg;
        start1 = 1'b0;
        unique case (phase_reg)
            PH_FIRST, PH_SECOND, PH_UP, PH_DOWN, PH_PAUSE, PH_LOOP: ;
            default: begin
                start1 = 1'b1;
                rep1   = 8'd0;
                ramp1  = 8'd0;
                hold1  = 16'd0;
                unique case (cfg.led_mode)
                    MODE_BLINK: begin
                        ph1   = PH_FIRST;
                        duty1 = cfg.led_level;
                    end
                    MODE_INVERT: begin
                        ph1   = PH_FIRST;
                        duty1 = 8'd0;
                    end
                    MODE_PULSE: begin
                        ph1   = PH_UP;
                        duty1 = 8'd0;
                    end
                    default: begin
                        ph1   = PH_LOOP;
                        duty1 = cfg.led_level;
                    end
                endcase
            end
        endcase
    end

    // Select the length of the current phase
    always_comb begin
        unique case (ph1)
            PH_FIRST, PH_SECOND: len = at_least_one(cfg.blink_interval);
            PH_UP, PH_DOWN:      len = at_least_one(cfg.pulse_interval);
            PH_PAUSE:            len = at_least_one(cfg.pause_ticks);
            default:             len = at_least_one(cfg.loop_ticks);
        endcase
    end

    assign phase_done = ({1'b0, hold1} + 17'd1) >= {1'b0, len};

    // Advance the hold timer or move to the next phase
    always_comb begin
        phase_next  = ph1;
        repeat_next = rep1;
        hold_next   = hold1 + 16'd1;
        ramp_next   = ramp1;
        duty_next   = duty1;
        if (phase_done) begin
            hold_next = 16'd0;
            unique case (ph1)
                PH_FIRST: begin
                    phase_next = PH_SECOND;
                    duty_next  = inverted ? cfg.led_level : 8'd0;
                end
                PH_SECOND: begin
                    if (rep1 >= cfg.blink_count) begin
                        phase_next = (cfg.pause_ticks == 16'd0) ? PH_LOOP : PH_PAUSE;
                    end else begin
                        repeat_next = rep1 + 8'd1;
                        phase_next  = PH_FIRST;
                        duty_next   = inverted ? 8'd0 : cfg.led_level;
                    end
                end
                PH_UP: begin
                    if (ramp_inc >= PEAK_DUTY) begin
                        ramp_next  = PEAK_DUTY;
                        phase_next = PH_DOWN;
                        duty_next  = PEAK_DUTY;
                    end else begin
                        ramp_next  = ramp_inc;
                        phase_next = PH_UP;
                        duty_next  = ramp_inc;
                    end
                end
                PH_DOWN: begin
                    if (ramp1 <= 8'd1) begin
                        ramp_next  = 8'd0;
                        phase_next = PH_LOOP;
                    end else begin
                        ramp_next  = ramp1 - 8'd1;
                        phase_next = PH_DOWN;
                        duty_next  = ramp1 - 8'd1;
                    end
                end
                PH_PAUSE: phase_next = PH_LOOP;
                default:  phase_next = PH_START;
            endcase
        end
    end

    // Report the duty; a report-only transaction sees the held duty
    assign duty       = tick ? duty1 : duty_reg;
    assign pass_start = tick && start1;

    // Hold pattern state; restart on a mode write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            repeat_reg <= 8'd0;
            hold_reg   <= 16'd0;
            ramp_reg   <= 8'd0;
            duty_reg   <= 8'd0;
        end else if (mode_wr) begin
            phase_reg  <= PH_START;
            repeat_reg <= 8'd0;
            hold_reg   <= 16'd0;
            ramp_reg   <= 8'd0;
        end else if (step && tick) begin
            phase_reg  <= phase_next;
            repeat_reg <= repeat_next;
            hold_reg   <= hold_next;
            ramp_reg   <= ramp_next;
            duty_reg   <= duty_next;
        end
    end

endmodule

[hw/rtl/status_led_pattern_generator.sv]
// Status LED pattern generator top level: input register, pattern core, result register.
//
// Each input transaction carries s_tick. With s_tick = 1 the block reports the
// duty driven during that tick and advances the pattern one tick; with
// s_tick = 0 it only reports the held duty. Every input transaction yields
// exactly one result transaction (m_duty, m_pass_start), in order.
// A result is registered: the input register feeds the core and the result
// register takes its output. Throughput: one transaction per cycle while the
// receiver takes results, as the phase and timer update is combinational.
// The input register keeps accepting while a result waits: when the receiver
// stalls, one transaction sits in the result register and one in the input
// register, then s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, loads the register
// defaults and puts the pattern at the start of a pass. Write configuration
// only while no transaction is in flight; a led_mode write restarts the
// pattern at the next tick.
`include "status_led_pattern_generator_macros.svh"
module status_led_pattern_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slpg_pkg::ADDR_W-1:0] paddr,
    input  logic [slpg_pkg::DATA_W-1:0] pwdata,
    output logic [slpg_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_tick,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_duty,
    output logic                        m_pass_start
);
    import slpg_pkg::*;

    cfg_t       cfg;
    logic       mode_wr;
    logic       in_valid_reg;
    logic       tick_reg;
    logic       m_valid_reg;
    logic [7:0] duty_reg;
    logic       start_reg;
    logic       advance;
    logic [7:0] core_duty;
    logic       core_start;

    slpg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .mode_wr (mode_wr)
    );

    slpg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .mode_wr    (mode_wr),
        .step       (advance),
        .tick       (tick_reg),
        .duty       (core_duty),
        .pass_start (core_start)
    );

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Capture an input transaction, drop it once it moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg <= s_tick;
        end
    end

    // Load the result register, release it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            duty_reg  <= core_duty;
            start_reg <= core_start;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_duty       = duty_reg;
    assign m_pass_start = start_reg;

    `SLPG_ASSERT_SAME(a_drain_when_free, aclk, aresetn, in_valid_reg && !m_valid_reg,
                      advance, "input stage stuck while result register is free")
    `SLPG_ASSERT_SAME(a_start_needs_tick, aclk, aresetn, advance && core_start,
                      tick_reg, "pass start reported without a tick")
    `SLPG_ASSERT_NEXT(a_result_after_advance, aclk, aresetn, advance,
                      m_valid, "advanced transaction did not reach the result register")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the status LED pattern generator: predictor, APB setup, handshakes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slpg_pkg::*;

    localparam int RAND_ITEMS      = 1280;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STUCK_LIMIT     = 2000;
    localparam int IDLE_PCT        = 7;

    // One result transaction: duty and first-tick-of-pass flag
    typedef struct packed {
        logic [7:0] duty;
        logic       pass_start;
    } led_out_t;

    // Pattern segments tracked by the predictor
    typedef enum logic [2:0] {
        SEG_NEW, SEG_FIRST, SEG_SECOND, SEG_RISE, SEG_FALL, SEG_PAUSE, SEG_LOOP
    } pat_seg_t;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    widx;
        logic [15:0] wval;
        logic        tick;
        logic        typed;
        led_out_t    want;
    } dir_row_t;

    localparam int DIR_ROWS = 41;

    // Directed sequence; typed rows carry values read straight off the spec
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // report only after reset, then steady level at default settings
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b0, 1'b1, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd20,  1'b1}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd20,  1'b0}},
        // shortened loop delay ends the current hold, zero loop acts as one
        '{ROW_WRITE, REG_LED_LEVEL,      16'd255,           1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_LOOP_TICKS,     16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        // blink with zero interval and no pause
        '{ROW_WRITE, REG_LED_MODE,       16'(MODE_BLINK),   1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_BLINK_COUNT,    16'd1,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_BLINK_INTERVAL, 16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_PAUSE_TICKS,    16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd255, 1'b1}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        // inverted blink, then lower the count in mid pass
        '{ROW_WRITE, REG_LED_MODE,       16'(MODE_INVERT),  1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_BLINK_COUNT,    16'd3,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_BLINK_INTERVAL, 16'd2,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_PAUSE_TICKS,    16'd2,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd0,   1'b1}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_BLINK_COUNT,    16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        // pulsate with the longest step, then shorten it under a running hold
        '{ROW_WRITE, REG_LED_MODE,       16'(MODE_PULSE),   1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_PULSE_INTERVAL, 16'hFFFF,          1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd0,   1'b1}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_PULSE_INTERVAL, 16'd1,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b0, '{8'd0,   1'b0}},
        // largest blink, pause and loop intervals, steady at level zero
        '{ROW_WRITE, REG_BLINK_INTERVAL, 16'hFFFF,          1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_PAUSE_TICKS,    16'hFFFF,          1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_LOOP_TICKS,     16'hFFFF,          1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_LED_LEVEL,      16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_WRITE, REG_LED_MODE,       16'(MODE_STEADY),  1'b0, 1'b0, '{8'd0,   1'b0}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b1, 1'b1, '{8'd0,   1'b1}},
        '{ROW_TICK,  REG_LED_MODE,       16'd0,             1'b0, 1'b0, '{8'd0,   1'b0}}
    };

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_tick  = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_duty;
    logic                 m_pass_start;

    // Predictor state and register copy
    cfg_t       led_cfg;
    pat_seg_t   seg;
    logic [7:0] rep_idx;
    logic [7:0] ramp_val;
    logic [7:0] cur_duty;
    logic [15:0] hold_cnt;

    led_out_t   led_expect_q[$];
    int         fail_count;
    int         stuck_cycles;
    bit         calm;
    bit         hold_off_req;
    int         hold_left;

    status_led_pattern_generator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_tick       (s_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_duty       (m_duty),
        .m_pass_start (m_pass_start)
    );

    // Clock: 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Enter a segment: clear the hold and latch its duty
    function automatic void seg_enter(input pat_seg_t s, input logic [7:0] d);
        seg      = s;
        hold_cnt = '0;
        cur_duty = d;
    endfunction

    // Mirror a register write into the predictor; a mode write restarts the pattern
    function automatic void led_cfg_write(input reg_idx_t idx, input logic [31:0] val);
        case (idx)
            REG_LED_MODE: begin
                led_cfg.led_mode = val[1:0];
                seg      = SEG_NEW;
                rep_idx  = '0;
                hold_cnt = '0;
                ramp_val = '0;
            end
            REG_BLINK_COUNT:    led_cfg.blink_count    = val[7:0];
            REG_LED_LEVEL:      led_cfg.led_level      = val[7:0];
            REG_BLINK_INTERVAL: led_cfg.blink_interval = val[15:0];
            REG_PULSE_INTERVAL: led_cfg.pulse_interval = val[15:0];
            REG_PAUSE_TICKS:    led_cfg.pause_ticks    = val[15:0];
            REG_LOOP_TICKS:     led_cfg.loop_ticks     = val[15:0];
            default: ;
        endcase
    endfunction

    // Work out the duty reported for one input transaction and advance one tick
    function automatic void predict_led_tick(input logic t, output logic [7:0] duty_o,
                                             output logic start_o);
        logic [15:0] seg_len;
        logic        inv;
        start_o = 1'b0;
        if (t && seg == SEG_NEW) begin
            rep_idx  = '0;
            ramp_val = '0;
            case (led_cfg.led_mode)
                MODE_BLINK:  seg_enter(SEG_FIRST, led_cfg.led_level);
                MODE_INVERT: seg_enter(SEG_FIRST, 8'd0);
                MODE_PULSE:  seg_enter(SEG_RISE, 8'd0);
                default:     seg_enter(SEG_LOOP, led_cfg.led_level);
            endcase
            start_o = 1'b1;
        end
        duty_o = cur_duty;
        if (t) begin
            case (seg)
                SEG_FIRST, SEG_SECOND: seg_len = led_cfg.blink_interval;
                SEG_RISE, SEG_FALL:    seg_len = led_cfg.pulse_interval;
                SEG_PAUSE:             seg_len = led_cfg.pause_ticks;
                default:               seg_len = led_cfg.loop_ticks;
            endcase
            if (seg_len == 16'd0) seg_len = 16'd1;
            inv = (led_cfg.led_mode == MODE_INVERT);
            if ({1'b0, hold_cnt} + 17'd1 >= {1'b0, seg_len}) begin
                case (seg)
                    SEG_FIRST: seg_enter(SEG_SECOND, inv ? led_cfg.led_level : 8'd0);
                    SEG_SECOND: begin
                        if (rep_idx >= led_cfg.blink_count) begin
                            seg_enter((led_cfg.pause_ticks == 16'd0) ? SEG_LOOP : SEG_PAUSE,
                                      cur_duty);
                        end else begin
                            rep_idx = rep_idx + 8'd1;
                            seg_enter(SEG_FIRST, inv ? 8'd0 : led_cfg.led_level);
                        end
                    end
                    SEG_RISE: begin
                        ramp_val = ramp_val + 8'd1;
                        if (ramp_val >= PEAK_DUTY) begin
                            ramp_val = PEAK_DUTY;
                            seg_enter(SEG_FALL, ramp_val);
                        end else begin
                            seg_enter(SEG_RISE, ramp_val);
                        end
                    end
                    SEG_FALL: begin
                        if (ramp_val <= 8'd1) begin
                            ramp_val = '0;
                            seg_enter(SEG_LOOP, cur_duty);
                        end else begin
                            ramp_val = ramp_val - 8'd1;
                            seg_enter(SEG_FALL, ramp_val);
                        end
                    end
                    SEG_PAUSE: seg_enter(SEG_LOOP, cur_duty);
                    default:   seg_enter(SEG_NEW, cur_duty);
                endcase
            end else begin
                hold_cnt = hold_cnt + 16'd1;
            end
        end
    endfunction

    // Offer one tick transaction; record its expected result once accepted
    task automatic send_tick(input logic t, input logic typed, input led_out_t want);
        led_out_t pred;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_tick  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_led_tick(t, pred.duty, pred.pass_start);
        led_expect_q.push_back(typed ? want : pred);
    endtask

    // Drop valid and hold until every expected result has arrived
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle completing on pready
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        settle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        led_cfg_write(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls, a long hold-off on request, none while calm
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_blk
        led_out_t exp_out;
        if (aresetn && m_valid && m_ready) begin
            if (led_expect_q.size() == 0) begin
                $error("m_duty: result with nothing expected, got %0d", m_duty);
                fail_count++;
            end else begin
                exp_out = led_expect_q.pop_front();
                if (m_duty !== exp_out.duty) begin
                    $error("m_duty: expected %0d, got %0d", exp_out.duty, m_duty);
                    fail_count++;
                end
                if (m_pass_start !== exp_out.pass_start) begin
                    $error("m_pass_start: expected %0d, got %0d",
                           exp_out.pass_start, m_pass_start);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus: reset, directed table, then random passes
    initial begin
        int  n_rand;
        int  phase_len;
        bit  stall_done;
        bit  drained;
        n_rand     = 0;
        stall_done = 1'b0;
        drained    = 1'b0;
        fail_count = 0;
        hold_left  = 0;
        led_cfg    = '{RST_LED_MODE, RST_BLINK_COUNT, RST_LED_LEVEL, RST_BLINK_INTERVAL,
                       RST_PULSE_INTERVAL, RST_PAUSE_TICKS, RST_LOOP_TICKS};
        seg        = SEG_NEW;
        rep_idx    = '0;
        ramp_val   = '0;
        cur_duty   = '0;
        hold_cnt   = '0;

        // Hold reset, then release it
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TAB[i].kind == ROW_WRITE)
                reg_write(DIR_TAB[i].widx, 32'(DIR_TAB[i].wval));
            else
                send_tick(DIR_TAB[i].tick, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // Random passes: fresh settings per phase, mostly short intervals
        while (n_rand < RAND_ITEMS) begin
            if ($urandom_range(1) != 0)
                reg_write(REG_BLINK_COUNT,
                          ($urandom_range(9) == 0) ? 255 : $urandom_range(4));
            if ($urandom_range(1) != 0)
                reg_write(REG_LED_LEVEL, $urandom_range(255));
            if ($urandom_range(1) != 0)
                reg_write(REG_BLINK_INTERVAL,
                          ($urandom_range(11) == 0) ? $urandom_range(65535) : $urandom_range(5));
            if ($urandom_range(1) != 0)
                reg_write(REG_PULSE_INTERVAL,
                          ($urandom_range(11) == 0) ? $urandom_range(65535) : $urandom_range(1));
            if ($urandom_range(1) != 0)
                reg_write(REG_PAUSE_TICKS,
                          ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(6));
            if ($urandom_range(1) != 0)
                reg_write(REG_LOOP_TICKS,
                          ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(5));
            if ($urandom_range(4) != 0)
                reg_write(REG_LED_MODE, $urandom_range(3));

            // Pulsate needs a long phase to reach the fall and the loop delay
            phase_len = (led_cfg.led_mode == MODE_PULSE) ? $urandom_range(450, 350)
                                                         : $urandom_range(150, 30);
            // Stop at the planned item count
            if (phase_len > RAND_ITEMS - n_rand) phase_len = RAND_ITEMS - n_rand;
            calm = (n_rand >= 500 && n_rand < 760);

            // Long receiver hold-off while the sender keeps offering
            if (!stall_done && n_rand >= 300 && !calm) begin
                hold_off_req = 1'b1;
                stall_done   = 1'b1;
            end

            // Sender pause until every result is back
            if (!drained && n_rand >= 900) begin
                settle();
                drained = 1'b1;
            end

            for (int k = 0; k < phase_len; k++)
                send_tick($urandom_range(99) < 85, 1'b0, '0);
            n_rand += phase_len;
        end
        calm = 1'b0;

        // Drain and let the pipeline run empty
        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && led_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/slpg_pkg.sv
hw/rtl/slpg_regs.sv
hw/rtl/slpg_core.sv
hw/rtl/status_led_pattern_generator.sv
tb/tb_top.sv
